>>> sv/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types, constants and helpers of the integer to radix ascii block.
// ----------------------------------------------------------------------------
package itra_pkg;

  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned RADIX_W      = 6;
  localparam int unsigned CHAR_W       = 7;
  localparam int unsigned DIGIT_W      = 5;
  localparam int unsigned MAX_DIGITS   = 32;
  localparam int unsigned DIG_IDX_W    = $clog2(MAX_DIGITS);
  localparam int unsigned DIG_CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int unsigned DIV_STEP_BITS = 8;
  localparam int unsigned DIV_STEPS    = VALUE_W / DIV_STEP_BITS;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 7'd65;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'd45;
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd32;
  localparam logic [RADIX_W-1:0] RADIX_TEN  = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 5'd10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_SIGN,
    S_EMIT
  } itra_state_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    logic [RADIX_W-1:0] radix;
    logic               is_signed;
  } itra_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last_char;
  } itra_out_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } itra_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic [DIGIT_W-1:0] rem;
  } itra_div_rsp_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + dx;
    end else begin
      return CHAR_A + dx - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
    end
  endfunction

endpackage

>>> sv/itra_div.sv
// ----------------------------------------------------------------------------
// itra_div
// Iterative restoring divider, 32-bit dividend by 6-bit divisor, eight
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module itra_div import itra_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  itra_div_req_t req_i,
  output itra_div_rsp_t rsp_o
);

  logic [VALUE_W-1:0]   w_q, w_d;
  logic [RADIX_W-1:0]   rem_q, rem_d;
  logic [RADIX_W-1:0]   divisor_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [VALUE_W-1:0]   w_s;
  logic [RADIX_W-1:0]   r_s;
  logic                 ge_s;
  logic                 last_step;

  // eight dependent subtract steps on the narrow remainder
  always_comb begin
    w_s  = w_q;
    r_s  = rem_q;
    ge_s = 1'b0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      r_s  = {r_s[RADIX_W-2:0], w_s[VALUE_W-1]};
      ge_s = (r_s >= divisor_q);
      w_s  = {w_s[VALUE_W-2:0], ge_s};
      if (ge_s) begin
        r_s = r_s - divisor_q;
      end
    end
  end

  assign last_step = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  always_comb begin
    w_d    = w_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      w_d    = req_i.dividend;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      w_d   = w_s;
      rem_d = r_s;
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      divisor_q <= req_i.divisor;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = w_q;
  assign rsp_o.rem  = rem_q[DIGIT_W-1:0];

endmodule

>>> sv/integer_to_radix_ascii.sv
// Sequence: each digit takes a start state, the divider's iterations and a
// wait for its result; the characters then go one per cycle into the output
// register while the output is not stalled. A new number is taken only once
// the previous number's last character is loaded; the shared divider sets the pace.
// Reset: asynchronous active low, clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a 32-bit value to ascii digits in radix 2 to 32, most significant
// first, with a leading minus for negative signed base-ten values.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii import itra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  itra_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output itra_out_t out_data_o
);

  itra_state_e          state_q, state_d;
  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic [RADIX_W-1:0]   radix_q, radix_d;
  logic                 minus_q, minus_d;
  logic [DIG_CNT_W-1:0] ndig_q, ndig_d;
  logic [DIG_IDX_W-1:0] idx_q, idx_d;
  logic [DIGIT_W-1:0]   buf_q [MAX_DIGITS];
  itra_out_t            out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  itra_div_req_t        div_req;
  itra_div_rsp_t        div_rsp;

  logic                 in_acc;
  logic                 radix_ok;
  logic                 out_ld;
  logic                 buf_we;
  logic                 neg_in;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign radix_ok   = (in_data_i.radix >= RADIX_MIN) && (in_data_i.radix <= RADIX_MAX);
  assign neg_in     = in_data_i.is_signed && (in_data_i.radix == RADIX_TEN) &&
                      in_data_i.value_bits[VALUE_W-1];
  assign out_ld     = !out_valid_q || !out_stall_i;

  itra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && radix_ok) begin
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quot != '0) begin
            state_d = S_START;
          end else if (minus_q) begin
            state_d = S_SIGN;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_SIGN: begin
        if (out_ld) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ld && (idx_q == '0)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    mag_d            = mag_q;
    radix_d          = radix_q;
    minus_d          = minus_q;
    ndig_d           = ndig_q;
    idx_d            = idx_q;
    out_d            = out_q;
    out_valid_d      = out_valid_q && out_stall_i;
    buf_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mag_q;
    div_req.divisor  = radix_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mag_d   = neg_in ? (VALUE_W'(0) - in_data_i.value_bits) : in_data_i.value_bits;
          radix_d = in_data_i.radix;
          minus_d = neg_in;
          ndig_d  = '0;
        end
      end
      S_START: begin
        div_req.start = 1'b1;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          buf_we = 1'b1;
          mag_d  = div_rsp.quot;
          ndig_d = ndig_q + 1'b1;
          idx_d  = ndig_q[DIG_IDX_W-1:0];
        end
      end
      S_SIGN: begin
        if (out_ld) begin
          out_d.ascii_char = CHAR_MINUS;
          out_d.last_char  = 1'b0;
          out_valid_d      = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ld) begin
          out_d.ascii_char = digit_to_ascii(buf_q[idx_q]);
          out_d.last_char  = (idx_q == '0);
          out_valid_d      = 1'b1;
          idx_d            = idx_q - 1'b1;
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ndig_q      <= '0;
      idx_q       <= '0;
      minus_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ndig_q      <= ndig_d;
      idx_q       <= idx_d;
      minus_q     <= minus_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    radix_q <= radix_d;
    out_q   <= out_d;
    if (buf_we) begin
      buf_q[ndig_q[DIG_IDX_W-1:0]] <= div_rsp.rem;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // divider answers only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == S_WAIT) && !div_rsp.busy))
    else $error("divider result outside wait state");

  // digit count never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= DIG_CNT_W'(MAX_DIGITS))
    else $error("digit buffer overrun");

  // out-of-range radix yields no work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !radix_ok) |=> (state_q == S_IDLE))
    else $error("bad radix started a conversion");

  // loading the least significant digit marks the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_ld && idx_q == '0) |=> (out_valid_o && out_data_o.last_char))
    else $error("final character not flagged");

endmodule
